// ===== design/dtcsm_pkg.sv =====
`timescale 1ns / 1ps
package dtcsm_pkg;
    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W = 3;
    localparam logic [7:0] CLEAR_STATUS = 8'h50;
    localparam logic [7:0] SAVE_MASK = 8'hBD;
    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_RESTORE = 3'd1;
    localparam logic [2:0] FN_TEST = 3'd2;
    localparam logic [2:0] FN_CYCLE = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;
    localparam logic [2:0] FN_COUNT = 3'd5;
    localparam logic [2:0] FN_REPMASK = 3'd6;
    localparam logic [2:0] FN_REPALL = 3'd7;
    localparam logic [1:0] OUT_PASS = 2'd0;
    localparam logic [1:0] OUT_FAIL = 2'd1;
    localparam logic [1:0] GRP_EMIS = 2'd0;
    localparam logic [1:0] GRP_NET = 2'd1;
    localparam logic [1:0] GRP_ALL = 2'd2;
    localparam logic [2:0] REG_DETECT = 3'd0;
    localparam logic [2:0] REG_AVAIL = 3'd1;
    localparam logic [2:0] REG_TRIP = 3'd2;
    localparam logic [2:0] REG_AGING = 3'd3;
    localparam logic [2:0] REG_EMIS_END = 3'd4;
    localparam logic [2:0] REG_NET_START = 3'd5;
    localparam logic [2:0] REG_NET_END = 3'd6;
    typedef logic [7:0] byte_t;
endpackage

// ===== design/dtc_status_manager_core.sv =====
`timescale 1ns / 1ps
// Diagnostic trouble code table of eight entries with ISO 14229 status bytes.
// An item is taken when start is high and busy is low; busy then stays high
// while the walk visits every entry and through the closing state. The walk
// visits one entry per cycle through a single shared
// entry-update unit. Cycle end and reports show their records during the walk,
// each in the cycle after its entry is visited, so the final record is shown
// while busy is still high. Single-entry commands (load, restore, test result),
// count, clear and a report with no record show their one result in the cycle
// after the closing cycle, when busy has already dropped. Either way the next
// item can be taken as soon as busy is low again.
// Each result is held on the outputs for exactly one cycle, marked by
// out_valid, and the receiver cannot hold it off, so it must take every one.
module dtc_status_manager_core
    import dtcsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [2:0]  entry_index,
    input  logic [23:0] dtc_code,
    input  logic [7:0]  saved_status,
    input  logic [1:0]  test_outcome,
    input  logic [1:0]  group_kind,
    input  logic [7:0]  status_mask,
    input  logic [3:0]  max_records,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    output logic        record_valid,
    output logic [2:0]  out_index,
    output logic [23:0] out_code,
    output logic [7:0]  out_status,
    output logic [3:0]  match_count,
    output logic        persist_write,
    output logic        snapshot_request,
    output logic        last
);

    // Configuration registers.
    logic        detect_reg;
    byte_t       avail_reg, trip_lim_reg, aging_lim_reg;
    logic [23:0] emis_end_reg, net_start_reg, net_end_reg;

    // Entry state. Codes have no reset; the rest resets to known values.
    logic [23:0] code_mem [NUM_ENTRIES];
    byte_t       status_reg [NUM_ENTRIES];
    byte_t       trip_reg [NUM_ENTRIES];
    byte_t       fault_reg [NUM_ENTRIES];
    byte_t       aging_reg [NUM_ENTRIES];

    // Latched command.
    logic [2:0]  func_reg;
    logic [2:0]  idx_reg;
    byte_t       saved_reg, mask_reg;
    logic [1:0]  outcome_reg, group_reg;
    logic [3:0]  maxr_reg;

    // Sequencer: walk over entries, then a closing state.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    logic [1:0]  state_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [3:0]  cnt_reg;   // matches, cleared entries or records sent
    logic        snap_reg;

    // Registered outputs.
    logic        ov_reg, rv_reg, pw_reg, sr_reg, last_reg;
    logic [2:0]  oi_reg;
    logic [23:0] oc_reg;
    byte_t       os_reg;
    logic [3:0]  mc_reg;

    // Shared entry-update unit: works on the entry at ptr_reg.
    byte_t       s_cur, t_cur, f_cur, a_cur;
    byte_t       s_new, t_new, f_new, a_new;
    logic [23:0] c_cur;
    logic        u_write, u_snap, u_hit, u_emit, walk_last;
    logic        more_after;
    byte_t       st_av;
    logic [3:0]  maxr_eff;

    always_comb
    begin
        s_cur = status_reg[ptr_reg];
        t_cur = trip_reg[ptr_reg];
        f_cur = fault_reg[ptr_reg];
        a_cur = aging_reg[ptr_reg];
        c_cur = code_mem[ptr_reg];
        s_new = s_cur;
        t_new = t_cur;
        f_new = f_cur;
        a_new = a_cur;
        u_write = 1'b0;
        u_snap = 1'b0;
        u_hit = 1'b0;
        u_emit = 1'b0;
        st_av = s_cur & avail_reg;
        maxr_eff = (maxr_reg > 4'd8) ? 4'd8 : maxr_reg;
        case (func_reg)
            FN_RESTORE:
            begin
                if (ptr_reg == idx_reg)
                begin
                    s_new = (saved_reg | 8'h40) & 8'hFD;
                    u_write = 1'b1;
                end
            end
            FN_TEST:
            begin
                if (ptr_reg == idx_reg && detect_reg)
                begin
                    u_write = 1'b1;
                    if (outcome_reg == OUT_PASS)
                        s_new = s_cur & ~8'h51;
                    else if (outcome_reg == OUT_FAIL)
                    begin
                        s_new = (s_cur & ~8'h50) | 8'h01;
                        if (!s_new[1])
                        begin
                            t_new = (t_cur != 8'hFF) ? t_cur + 8'd1 : t_cur;
                            if (t_new >= trip_lim_reg)
                            begin
                                s_new[1] = 1'b1;
                                if (!s_new[3])
                                begin
                                    t_new = 8'd0;
                                    s_new[3] = 1'b1;
                                end
                                u_snap = 1'b1;
                            end
                            f_new = (f_cur != 8'hFF) ? f_cur + 8'd1 : f_cur;
                        end
                        s_new = s_new | 8'h24;
                        a_new = 8'd0;
                    end
                    if (!s_new[1] && !s_new[6])
                        t_new = 8'd0;
                end
            end
            FN_CYCLE:
            begin
                u_write = 1'b1;
                u_emit = 1'b1;
                if (!s_cur[4] && !s_cur[1])
                    s_new[2] = 1'b0;
                if (!s_cur[1] && s_cur[3])
                begin
                    if (a_cur >= aging_lim_reg)
                    begin
                        s_new = CLEAR_STATUS;
                        f_new = 8'd0;
                        a_new = 8'd0;
                        t_new = 8'd0;
                    end
                    else
                        a_new = (a_cur != 8'hFF) ? a_cur + 8'd1 : a_cur;
                end
                else
                    a_new = 8'd0;
                s_new = s_new & SAVE_MASK;
            end
            FN_CLEAR:
            begin
                case (group_reg)
                    GRP_EMIS: u_hit = (c_cur <= emis_end_reg);
                    GRP_NET:  u_hit = (c_cur >= net_start_reg) && (c_cur <= net_end_reg);
                    GRP_ALL:  u_hit = 1'b1;
                    default:  u_hit = 1'b0;
                endcase
                if (u_hit)
                begin
                    u_write = 1'b1;
                    s_new = CLEAR_STATUS;
                    t_new = 8'd0;
                    f_new = 8'd0;
                    a_new = 8'd0;
                end
            end
            FN_COUNT:
                u_hit = ((st_av & mask_reg) != 8'd0);
            FN_REPMASK:
                u_emit = ((st_av & mask_reg) != 8'd0) && (cnt_reg < maxr_eff);
            FN_REPALL:
                u_emit = (cnt_reg < maxr_eff);
            default:
                u_write = 1'b0;
        endcase
        walk_last = (ptr_reg == IDX_W'(NUM_ENTRIES - 1));
        // A report record is the final one when no later entry would be reported.
        more_after = 1'b0;
        for (int j = 0; j < NUM_ENTRIES; j++)
        begin
            if (IDX_W'(j) > ptr_reg && (func_reg == FN_REPALL
                || ((status_reg[j] & avail_reg & mask_reg) != 8'd0)))
                more_after = 1'b1;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_reg <= 1'b1;
            avail_reg <= 8'hFF;
            trip_lim_reg <= 8'd50;
            aging_lim_reg <= 8'd40;
            emis_end_reg <= 24'd0;
            net_start_reg <= 24'd0;
            net_end_reg <= 24'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DETECT:    detect_reg <= cfg_data[0];
                REG_AVAIL:     avail_reg <= cfg_data[7:0];
                REG_TRIP:      trip_lim_reg <= cfg_data[7:0];
                REG_AGING:     aging_lim_reg <= cfg_data[7:0];
                REG_EMIS_END:  emis_end_reg <= cfg_data;
                REG_NET_START: net_start_reg <= cfg_data;
                REG_NET_END:   net_end_reg <= cfg_data;
                default:       detect_reg <= detect_reg;
            endcase
        end
    end

    // Code memory: written by load, read at the walk pointer and at the latched index.
    always_ff @(posedge clk)
    begin
        if (start && !busy && func == FN_LOAD)
            code_mem[entry_index] <= dtc_code;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func;
            idx_reg <= entry_index;
            saved_reg <= saved_status;
            outcome_reg <= test_outcome;
            group_reg <= group_kind;
            mask_reg <= status_mask;
            maxr_reg <= max_records;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                status_reg[i] <= CLEAR_STATUS;
                trip_reg[i] <= 8'd0;
                fault_reg[i] <= 8'd0;
                aging_reg[i] <= 8'd0;
            end
            state_reg <= ST_IDLE;
            ptr_reg <= '0;
            cnt_reg <= 4'd0;
            snap_reg <= 1'b0;
            ov_reg <= 1'b0;
            rv_reg <= 1'b0;
            pw_reg <= 1'b0;
            sr_reg <= 1'b0;
            last_reg <= 1'b0;
            oi_reg <= 3'd0;
            oc_reg <= 24'd0;
            os_reg <= 8'd0;
            mc_reg <= 4'd0;
        end
        else
        begin
            ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_WALK;
                        ptr_reg <= '0;
                        cnt_reg <= 4'd0;
                        snap_reg <= 1'b0;
                    end
                end
                ST_WALK:
                begin
                    if (u_write)
                    begin
                        status_reg[ptr_reg] <= s_new;
                        trip_reg[ptr_reg] <= t_new;
                        fault_reg[ptr_reg] <= f_new;
                        aging_reg[ptr_reg] <= a_new;
                    end
                    if (u_snap)
                        snap_reg <= 1'b1;
                    if (u_hit)
                        cnt_reg <= cnt_reg + 4'd1;
                    if (u_emit)
                    begin
                        ov_reg <= 1'b1;
                        rv_reg <= 1'b1;
                        oi_reg <= ptr_reg;
                        oc_reg <= c_cur;
                        os_reg <= (func_reg == FN_CYCLE) ? s_new : st_av;
                        mc_reg <= 4'd0;
                        pw_reg <= (func_reg == FN_CYCLE);
                        sr_reg <= 1'b0;
                        last_reg <= (func_reg == FN_CYCLE) ? walk_last
                                    : ((cnt_reg + 4'd1 == maxr_eff) || !more_after);
                        if (func_reg != FN_CYCLE)
                            cnt_reg <= cnt_reg + 4'd1;
                    end
                    if (walk_last)
                        state_reg <= ST_DONE;
                    else
                        ptr_reg <= ptr_reg + 1'b1;
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                    ov_reg <= 1'b1;
                    rv_reg <= 1'b0;
                    oi_reg <= 3'd0;
                    oc_reg <= 24'd0;
                    os_reg <= 8'd0;
                    mc_reg <= 4'd0;
                    pw_reg <= 1'b0;
                    sr_reg <= 1'b0;
                    last_reg <= 1'b1;
                    case (func_reg)
                        FN_LOAD, FN_RESTORE, FN_TEST:
                        begin
                            rv_reg <= 1'b1;
                            oi_reg <= idx_reg;
                            oc_reg <= code_mem[idx_reg];
                            os_reg <= status_reg[idx_reg];
                            pw_reg <= snap_reg;
                            sr_reg <= snap_reg;
                        end
                        FN_CLEAR, FN_COUNT:
                            mc_reg <= cnt_reg;
                        FN_CYCLE:
                            ov_reg <= 1'b0;
                        default:
                            ov_reg <= (cnt_reg == 4'd0);
                    endcase
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign record_valid = rv_reg;
    assign out_index = oi_reg;
    assign out_code = oc_reg;
    assign out_status = os_reg;
    assign match_count = mc_reg;
    assign persist_write = pw_reg;
    assign snapshot_request = sr_reg;
    assign last = last_reg;

    // A snapshot request always comes with a persistent write.
    a_snap_pw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && snapshot_request |-> persist_write)
        else $error("snapshot without persist write");
    // No result while idle unless the walk just finished.
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
        else $error("result without a command in flight");
    // The closing state always returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> state_reg == ST_IDLE)
        else $error("sequencer stuck after walk");

endmodule
